// ===== rtl/kmp_stream_matcher_assert.svh =====
// assertion macros for the matcher, empty when SYNTH is set
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define KSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define KSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KSM_ASSERT_IMP(lbl, ante, cons, msg)
`define KSM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/kmpsm_pkg.sv =====
package kmpsm_pkg;

    localparam int SYMBOL_W   = 8;
    localparam int CMD_W      = 2;
    localparam int START_W    = 32;
    localparam int COUNT_W    = 32;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2
    } cmd_t;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CMP   = 6'b000100,
        S_MATCH = 6'b001000,
        S_FALL  = 6'b010000,
        S_END   = 6'b100000
    } state_t;

endpackage

// ===== rtl/kmp_stream_matcher.sv =====
// steps: a clear, a first or dropped pattern byte or a text byte on an empty pattern is
// taken in idle alone; any other byte is accepted, then compared, with a read state and
// another compare for every back-off step (pattern and failure memory read); a full match
// adds the result and failure read states, an end result the end state, each held while the output beat waits
// throughput: one byte at a time, set by the shared compare loop over the two memories
// reset: asynchronous, clears lengths, counters and flags; the memories are not cleared
`include "kmp_stream_matcher_assert.svh"

module kmp_stream_matcher #(
    parameter int PATTERN_MAX   = 256,
    parameter int POSITION_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [kmpsm_pkg::SYMBOL_W-1:0]       s_axis_tdata,   // symbol
    input  logic [kmpsm_pkg::CMD_W-1:0]          s_axis_tuser,   // command
    input  logic                                 s_axis_tlast,   // end_of_text
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // start_position [31:0], match_count [63:32], pattern_overflow [64], zero fill
    output logic [kmpsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tuser,   // kind
    output logic                                 m_axis_tlast    // last
);
    import kmpsm_pkg::*;

    localparam int ADDR_W = $clog2(PATTERN_MAX);
    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int CW     = (POSITION_BITS + 1 > LEN_W) ? POSITION_BITS + 1 : LEN_W;
    localparam int SW     = (CW > START_W) ? CW : START_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

    state_t                     state_reg, state_next;
    logic [LEN_W-1:0]           pat_len_reg, pat_len_next;
    logic [ADDR_W-1:0]          bpl_reg, bpl_next;
    logic [ADDR_W-1:0]          matched_reg, matched_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [POSITION_BITS-1:0]   cur_reg, cur_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic                       ovf_reg, ovf_next;
    logic [LEN_W-1:0]           j_reg, j_next;
    logic [SYMBOL_W-1:0]        sym_reg, sym_next;
    logic                       build_reg, build_next;
    logic                       eot_reg, eot_next;

    logic [SYMBOL_W-1:0]        pat_mem [PATTERN_MAX];
    logic [ADDR_W-1:0]          fail_mem [PATTERN_MAX];
    logic [SYMBOL_W-1:0]        pat_q;
    logic [ADDR_W-1:0]          fail_q;

    logic                       pat_we, fail_we;
    logic [ADDR_W-1:0]          pat_waddr, fail_waddr;
    logic [SYMBOL_W-1:0]        pat_wdata;
    logic [ADDR_W-1:0]          fail_wdata;
    logic [LEN_W-1:0]           walk_j;
    logic [ADDR_W-1:0]          pat_raddr, fail_raddr;

    logic                       out_valid_reg;
    logic                       out_kind_reg, out_ovf_reg, out_last_reg;
    logic [START_W-1:0]         out_start_reg;
    logic [COUNT_W-1:0]         out_count_reg;

    logic                       accept, slot_free, sym_hit, out_load;
    cmd_t                       in_cmd;
    logic [LEN_W-1:0]           j_step;
    logic [CW-1:0]              cur_ext, plen_ext, start_full;
    logic [SW-1:0]              start_wide;
    logic [COUNT_W-1:0]         count_inc;
    logic                       load_kind, load_last;
    logic [START_W-1:0]         load_start;
    logic [COUNT_W-1:0]         load_count;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = cmd_t'(s_axis_tuser);
    assign slot_free     = !out_valid_reg || m_axis_tready;

    // read address comes straight from the incoming beat so the compare follows at once
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            walk_j = (in_cmd == CMD_APPEND) ? LEN_W'(bpl_reg) : LEN_W'(matched_reg);
        end
        else
        begin
            walk_j = j_reg;
        end
    end

    assign pat_raddr  = walk_j[ADDR_W-1:0];
    assign fail_raddr = ADDR_W'(walk_j - LEN_W'(1));

    assign sym_hit   = (pat_q == sym_reg);
    assign j_step    = j_reg + LEN_W'(sym_hit);
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);

    // start of match, clamped at zero
    assign cur_ext    = CW'(cur_reg) + CW'(1);
    assign plen_ext   = CW'(pat_len_reg);
    assign start_full = (cur_ext >= plen_ext) ? cur_ext - plen_ext : '0;
    assign start_wide = SW'(start_full);

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= pat_wdata;
        end
        pat_q <= pat_mem[pat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fail_q <= fail_mem[fail_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        pat_len_next = pat_len_reg;
        bpl_next     = bpl_reg;
        matched_next = matched_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        j_next       = j_reg;
        sym_next     = sym_reg;
        build_next   = build_reg;
        eot_next     = eot_reg;
        pat_we       = 1'b0;
        pat_waddr    = pat_len_reg[ADDR_W-1:0];
        pat_wdata    = s_axis_tdata;
        fail_we      = 1'b0;
        fail_waddr   = pat_len_reg[ADDR_W-1:0];
        fail_wdata   = j_step[ADDR_W-1:0];
        out_load     = 1'b0;
        load_kind    = KIND_MATCH;
        load_start   = '0;
        load_count   = count_reg;
        load_last    = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sym_next = s_axis_tdata;
                    eot_next = s_axis_tlast;
                    case (in_cmd)
                        CMD_CLEAR:
                        begin
                            pat_len_next = '0;
                            bpl_next     = '0;
                            matched_next = '0;
                            pos_next     = '0;
                            count_next   = '0;
                            ovf_next     = 1'b0;
                        end
                        CMD_APPEND:
                        begin
                            if (pat_len_reg == LEN_MAX)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                pat_we     = 1'b1;
                                build_next = 1'b1;
                                if (pat_len_reg == '0)
                                begin
                                    fail_we      = 1'b1;
                                    fail_wdata   = '0;
                                    bpl_next     = '0;
                                    pat_len_next = LEN_W'(1);
                                end
                                else
                                begin
                                    j_next     = LEN_W'(bpl_reg);
                                    state_next = S_CMP;
                                end
                            end
                        end
                        CMD_TEXT:
                        begin
                            cur_next   = pos_reg;
                            build_next = 1'b0;
                            if (pos_reg != '1)
                            begin
                                pos_next = pos_reg + POSITION_BITS'(1);
                            end
                            if (pat_len_reg != '0)
                            begin
                                j_next     = LEN_W'(matched_reg);
                                state_next = S_CMP;
                            end
                            else if (s_axis_tlast)
                            begin
                                state_next = S_END;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (j_reg != '0 && !sym_hit)
                begin
                    // back off through the failure table
                    j_next     = LEN_W'(fail_q);
                    state_next = S_READ;
                end
                else if (build_reg)
                begin
                    fail_we      = 1'b1;
                    bpl_next     = j_step[ADDR_W-1:0];
                    pat_len_next = pat_len_reg + LEN_W'(1);
                    state_next   = S_IDLE;
                end
                else
                begin
                    j_next = j_step;
                    if (j_step == pat_len_reg)
                    begin
                        state_next = S_MATCH;
                    end
                    else
                    begin
                        matched_next = j_step[ADDR_W-1:0];
                        state_next   = eot_reg ? S_END : S_IDLE;
                    end
                end
            end
            S_MATCH:
            begin
                // failure entry of the full match is read meanwhile
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    load_kind  = KIND_MATCH;
                    load_start = start_wide[START_W-1:0];
                    load_count = count_inc;
                    load_last  = !eot_reg;
                    count_next = count_inc;
                    state_next = S_FALL;
                end
            end
            S_FALL:
            begin
                matched_next = fail_q;
                state_next   = eot_reg ? S_END : S_IDLE;
            end
            S_END:
            begin
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    load_kind    = KIND_END;
                    load_start   = '0;
                    load_count   = count_reg;
                    load_last    = 1'b1;
                    matched_next = '0;
                    pos_next     = '0;
                    count_next   = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pat_len_reg   <= '0;
            bpl_reg       <= '0;
            matched_reg   <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            build_reg     <= 1'b0;
            eot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pat_len_reg <= pat_len_next;
            bpl_reg     <= bpl_next;
            matched_reg <= matched_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            build_reg   <= build_next;
            eot_reg     <= eot_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        j_reg   <= j_next;
        sym_reg <= sym_next;
        if (out_load)
        begin
            out_kind_reg  <= load_kind;
            out_start_reg <= load_start;
            out_count_reg <= load_count;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= load_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - START_W - COUNT_W - 1){1'b0}},
                            out_ovf_reg, out_count_reg, out_start_reg};

    `KSM_ASSERT_IMP(a_matched_below_len, (state_reg == S_IDLE) && (pat_len_reg != '0), LEN_W'(matched_reg) < pat_len_reg, "matched length reached pattern length")
    `KSM_ASSERT_IMP(a_prefix_below_len, (state_reg == S_IDLE) && (pat_len_reg != '0), LEN_W'(bpl_reg) < pat_len_reg, "build prefix length out of range")
    `KSM_ASSERT_IMP(a_walk_in_range, state_reg == S_CMP, j_reg < pat_len_reg, "walk index beyond stored pattern")
    `KSM_ASSERT_IMP(a_match_full, state_reg == S_MATCH, (j_reg == pat_len_reg) && !build_reg, "match state without full match")
    `KSM_ASSERT_NXT(a_end_after_eot, (state_reg == S_END) && slot_free, (state_reg == S_IDLE) && (count_reg == '0), "end result did not restart text")

endmodule

// ===== dv/tb_kmp_stream_matcher.sv =====
`timescale 1ns / 100ps

module tb_kmp_stream_matcher;

    import kmpsm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PAT_DEPTH    = 256;
    localparam int RANDOM_ITEMS = 700;
    localparam int DIR_ROWS     = 21;

    typedef struct packed {
        logic        kind;
        logic [31:0] start;
        logic [31:0] count;
        logic        ovf;
        logic        last;
    } match_beat_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [7:0]       sym;
        logic             eot;
        bit               typed;      // expectation written out by hand
        int               n_typed;
        match_beat_t      res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SYMBOL_W-1:0]   s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // shadow of the matcher state
    logic [7:0]  pat_mem [PAT_DEPTH];
    logic [7:0]  back_mem [PAT_DEPTH];
    logic [8:0]  pat_len;
    logic [8:0]  build_len;
    logic [8:0]  run_len;
    logic [31:0] text_pos;
    logic [31:0] hit_count;
    logic        dropped;

    match_beat_t step_results[$];
    match_beat_t match_results_due[$];

    int unsigned mismatches;
    int unsigned items_sent;
    bit          calm;

    stim_row_t dir_rows [DIR_ROWS] = '{
        // empty pattern straight after reset: only the end beat
        '{CMD_TEXT,   8'h41, 1'b1, 1'b1, 1, '{KIND_END, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{CMD_UNUSED, 8'hFF, 1'b1, 1'b1, 0, '0},
        // end of text on an append is ignored
        '{CMD_APPEND, 8'h00, 1'b1, 1'b0, 0, '0},
        '{CMD_APPEND, 8'hFF, 1'b0, 1'b0, 0, '0},
        '{CMD_APPEND, 8'h00, 1'b0, 1'b0, 0, '0},
        '{CMD_TEXT,   8'h00, 1'b0, 1'b0, 0, '0},
        '{CMD_TEXT,   8'hFF, 1'b0, 1'b0, 0, '0},
        '{CMD_TEXT,   8'h00, 1'b0, 1'b0, 0, '0},
        '{CMD_TEXT,   8'hFF, 1'b0, 1'b0, 0, '0},
        // overlapping hit
        '{CMD_TEXT,   8'h00, 1'b0, 1'b0, 0, '0},
        '{CMD_TEXT,   8'h00, 1'b1, 1'b0, 0, '0},
        '{CMD_CLEAR,  8'hFF, 1'b1, 1'b1, 0, '0},
        '{CMD_TEXT,   8'h00, 1'b1, 1'b1, 1, '{KIND_END, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{CMD_APPEND, 8'h41, 1'b0, 1'b0, 0, '0},
        // hit and end beat from the same byte
        '{CMD_TEXT,   8'h41, 1'b1, 1'b0, 0, '0},
        '{CMD_UNUSED, 8'h00, 1'b0, 1'b1, 0, '0},
        '{CMD_TEXT,   8'h41, 1'b0, 1'b0, 0, '0},
        // pattern grows in the middle of a text
        '{CMD_APPEND, 8'h41, 1'b0, 1'b0, 0, '0},
        '{CMD_TEXT,   8'h41, 1'b0, 1'b0, 0, '0},
        '{CMD_TEXT,   8'h41, 1'b0, 1'b0, 0, '0},
        '{CMD_TEXT,   8'h41, 1'b1, 1'b0, 0, '0}
    };

    kmp_stream_matcher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[kmp_stream_matcher] ERROR");
        $finish;
    end

    function automatic void kmp_advance(logic [CMD_W-1:0] cmd, logic [7:0] sym, logic eot);
        logic [8:0]  j;
        logic [8:0]  k;
        logic [31:0] cur;
        logic [32:0] start;
        match_beat_t beat;
        step_results.delete();
        if (cmd == CMD_CLEAR)
        begin
            pat_len   = '0;
            build_len = '0;
            run_len   = '0;
            text_pos  = '0;
            hit_count = '0;
            dropped   = 1'b0;
        end
        else if (cmd == CMD_APPEND)
        begin
            if (pat_len >= 9'(PAT_DEPTH))
                dropped = 1'b1;
            else
            begin
                pat_mem[pat_len[7:0]] = sym;
                k = build_len;
                if (pat_len == '0)
                    k = '0;
                else
                begin
                    while (k != '0 && pat_mem[k[7:0]] != sym)
                        k = {1'b0, back_mem[8'(k - 9'd1)]};
                    if (pat_mem[k[7:0]] == sym)
                        k = k + 9'd1;
                end
                back_mem[pat_len[7:0]] = k[7:0];
                build_len = k;
                pat_len   = pat_len + 9'd1;
            end
        end
        else if (cmd == CMD_TEXT)
        begin
            cur = text_pos;
            if (text_pos != '1)
                text_pos = text_pos + 32'd1;
            if (pat_len != '0)
            begin
                j = run_len;
                while (j != '0 && pat_mem[j[7:0]] != sym)
                    j = {1'b0, back_mem[8'(j - 9'd1)]};
                if (pat_mem[j[7:0]] == sym)
                    j = j + 9'd1;
                if (j == pat_len)
                begin
                    // a start before index zero only arises once the position saturates
                    if (33'(cur) + 33'd1 >= 33'(pat_len))
                        start = 33'(cur) + 33'd1 - 33'(pat_len);
                    else
                        start = '0;
                    if (hit_count != '1)
                        hit_count = hit_count + 32'd1;
                    beat = '{KIND_MATCH, start[31:0], hit_count, dropped, ~eot};
                    step_results = {step_results, beat};
                    j = {1'b0, back_mem[8'(j - 9'd1)]};
                end
                run_len = j;
            end
            if (eot)
            begin
                beat = '{KIND_END, 32'd0, hit_count, dropped, 1'b1};
                step_results = {step_results, beat};
                run_len   = '0;
                text_pos  = '0;
                hit_count = '0;
            end
        end
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(string what);
        if (mismatches < 100)
            $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // leaves tvalid high on return: the caller drives the next beat or drops it in this step
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [7:0] sym, logic eot, bit typed);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        kmp_advance(cmd, sym, eot);
        if (!typed)
            foreach (step_results[i])
                match_results_due = {match_results_due, step_results[i]};
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (match_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_beat();
        match_beat_t want;
        if (match_results_due.size() == 0)
        begin
            flag_mismatch($sformatf("beat with nothing expected, tdata %h", m_axis_tdata));
            return;
        end
        want = match_results_due.pop_front();
        if (m_axis_tuser !== want.kind)
            flag_mismatch($sformatf("kind %b want %b", m_axis_tuser, want.kind));
        if (m_axis_tdata[31:0] !== want.start)
            flag_mismatch($sformatf("start %0d want %0d", m_axis_tdata[31:0], want.start));
        if (m_axis_tdata[63:32] !== want.count)
            flag_mismatch($sformatf("count %0d want %0d", m_axis_tdata[63:32], want.count));
        if (m_axis_tdata[64] !== want.ovf)
            flag_mismatch($sformatf("overflow %b want %b", m_axis_tdata[64], want.ovf));
        if (m_axis_tlast !== want.last)
            flag_mismatch($sformatf("last %b want %b", m_axis_tlast, want.last));
    endtask

    // output side with random back-pressure
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
                check_beat();
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    task automatic run_random();
        int unsigned seq_idx;
        int unsigned mode;
        int unsigned alpha_n;
        int unsigned plen;
        int unsigned tlen;
        logic [7:0]  alpha [3];
        logic [7:0]  sym;
        seq_idx    = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (seq_idx != 2 && $urandom_range(0, 99) < 6)
            begin
                // noise: unused command codes
                repeat ($urandom_range(1, 4))
                    send_beat(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b0);
            end
            else
            begin
                if ($urandom_range(0, 9) != 0)
                    send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b0);
                mode = $urandom_range(0, 9);
                if (mode < 3)
                begin
                    alpha[0] = 8'h00;
                    alpha[1] = 8'hFF;
                    alpha_n  = 2;
                end
                else
                begin
                    alpha[0] = 8'($urandom_range(0, 255));
                    alpha[1] = 8'($urandom_range(0, 255));
                    alpha[2] = 8'($urandom_range(0, 255));
                    alpha_n  = $urandom_range(1, 3);
                end
                if (seq_idx == 2 || $urandom_range(0, 149) == 0)
                    plen = $urandom_range(255, 262);   // ends near the pattern capacity, mostly past it
                else if ($urandom_range(0, 19) == 0)
                    plen = 0;
                else
                    plen = $urandom_range(1, 6);
                repeat (plen)
                begin
                    sym = (mode == 9) ? 8'($urandom_range(0, 255))
                                      : alpha[$urandom_range(0, alpha_n - 1)];
                    send_beat(CMD_APPEND, sym, 1'($urandom_range(0, 7) == 0), 1'b0);
                end
                tlen = $urandom_range(0, 40);
                repeat (tlen)
                begin
                    sym = (mode == 9) ? 8'($urandom_range(0, 255))
                                      : alpha[$urandom_range(0, alpha_n - 1)];
                    if ($urandom_range(0, 29) == 0)
                        send_beat(CMD_APPEND, sym, 1'b0, 1'b0);
                    else
                        send_beat(CMD_TEXT, sym, 1'b0, 1'b0);
                end
                if ($urandom_range(0, 7) != 0)
                    send_beat(CMD_TEXT, alpha[$urandom_range(0, alpha_n - 1)], 1'b1, 1'b0);
            end
            calm = ($urandom_range(0, 5) == 0);
            if (seq_idx % 12 == 5)
            begin
                wait_drained();
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            seq_idx++;
        end
    endtask

    initial
    begin
        mismatches = 0;
        items_sent = 0;
        calm       = 1'b0;
        pat_len    = '0;
        build_len  = '0;
        run_len    = '0;
        text_pos   = '0;
        hit_count  = '0;
        dropped    = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_CLEAR;
        s_axis_tlast  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].typed && dir_rows[i].n_typed != 0)
                match_results_due = {match_results_due, dir_rows[i].res};
            send_beat(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].eot, dir_rows[i].typed);
        end
        run_random();
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && match_results_due.size() == 0)
            $display("[kmp_stream_matcher] OK");
        else
            $display("[kmp_stream_matcher] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kmpsm_pkg.sv
rtl/kmp_stream_matcher.sv
dv/tb_kmp_stream_matcher.sv
